// ===== sv/dfo_pkg.sv =====
// ----------------------------------------------------------------------------
// dfo_pkg
// Shared types, widths and helpers for the depth-first order core.
// ----------------------------------------------------------------------------
package dfo_pkg;

  // Vertex numbers as they travel on the ports
  localparam int VERT_W = 6;
  // Widest adjacency row handled by the lowest-set-bit search
  localparam int ROW_W = 64;
  // Stream data widths, padded to whole bytes
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 8;

  // Edge write / row read request to the adjacency store
  typedef struct packed {
    logic              wr_en;
    logic [VERT_W-1:0] wr_a;
    logic [VERT_W-1:0] wr_b;
    logic [VERT_W-1:0] rd_v;
    logic              clear;
  } adj_req_t;

  // Push / read request to the walk stack
  typedef struct packed {
    logic              push;
    logic [VERT_W-1:0] push_ptr;
    logic [VERT_W-1:0] push_vertex;
    logic [VERT_W-1:0] rd_ptr;
  } stk_req_t;

  // Index of the lowest set bit of a 64-bit row (0 when the row is empty).
  // Two levels of eight: lowest bit per byte, then lowest non-empty byte.
  function automatic logic [VERT_W-1:0] lowest_set(input logic [ROW_W-1:0] x);
    logic [7:0]      grp_nz;
    logic [2:0]      grp_idx [8];
    logic [2:0]      sel;
    for (int g = 0; g < 8; g++) begin
      grp_nz[g]  = |x[g*8 +: 8];
      grp_idx[g] = 3'd0;
      for (int k = 7; k >= 0; k--) begin
        if (x[g*8 + k]) grp_idx[g] = 3'(k);
      end
    end
    sel = 3'd0;
    for (int g = 7; g >= 0; g--) begin
      if (grp_nz[g]) sel = 3'(g);
    end
    return {sel, grp_idx[sel]};
  endfunction

endpackage

// ===== sv/dfo_adj.sv =====
// ----------------------------------------------------------------------------
// dfo_adj
// Adjacency store. Two row memories: one written at row a with bit b, the
// other at row b with bit a, so one edge costs one write to each. A row
// reads as the OR of both. Per-row valid bits make a row that has not been
// written since the last clear read as zero.
// ----------------------------------------------------------------------------
module dfo_adj #(
  parameter int VERTICES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  dfo_pkg::adj_req_t   req,
  output logic [VERTICES-1:0] rd_row
);

  localparam int IDX_W = $clog2(VERTICES);

  logic [VERTICES-1:0] fwd_mem [VERTICES];
  logic [VERTICES-1:0] rev_mem [VERTICES];
  logic [VERTICES-1:0] fwd_vld;
  logic [VERTICES-1:0] rev_vld;
  logic [VERTICES-1:0] fwd_q;
  logic [VERTICES-1:0] rev_q;
  logic                fwd_ok;
  logic                rev_ok;
  logic [IDX_W-1:0]    ia;
  logic [IDX_W-1:0]    ib;
  logic [IDX_W-1:0]    ir;
  logic [VERTICES-1:0] onehot_a;
  logic [VERTICES-1:0] onehot_b;

  assign ia = req.wr_a[IDX_W-1:0];
  assign ib = req.wr_b[IDX_W-1:0];
  assign ir = req.rd_v[IDX_W-1:0];
  assign onehot_a = {{(VERTICES-1){1'b0}}, 1'b1} << ia;
  assign onehot_b = {{(VERTICES-1){1'b0}}, 1'b1} << ib;

  // Row valid bits, dropped all at once after a walk
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      fwd_vld <= '0;
      rev_vld <= '0;
      fwd_ok  <= 1'b0;
      rev_ok  <= 1'b0;
    end else begin
      if (req.wr_en) begin
        fwd_vld[ia] <= 1'b1;
        rev_vld[ib] <= 1'b1;
      end
      fwd_ok <= fwd_vld[ir];
      rev_ok <= rev_vld[ir];
    end
  end

  // Forward memory: first write of a row replaces it, later ones set a bit
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      if (fwd_vld[ia]) begin
        fwd_mem[ia][ib] <= 1'b1;
      end else begin
        fwd_mem[ia] <= onehot_b;
      end
    end
    fwd_q <= fwd_mem[ir];
  end

  // Reverse memory: same edge, transposed
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      if (rev_vld[ib]) begin
        rev_mem[ib][ia] <= 1'b1;
      end else begin
        rev_mem[ib] <= onehot_a;
      end
    end
    rev_q <= rev_mem[ir];
  end

  assign rd_row = (fwd_q & {VERTICES{fwd_ok}}) | (rev_q & {VERTICES{rev_ok}});

endmodule

// ===== sv/dfo_stack.sv =====
// ----------------------------------------------------------------------------
// dfo_stack
// Walk stack memory: one push write and one registered read per cycle.
// Entries are to be read only after they were pushed; the stack does not enforce it.
// ----------------------------------------------------------------------------
module dfo_stack #(
  parameter int VERTICES = 64
) (
  input  logic                        clk,
  input  dfo_pkg::stk_req_t           req,
  output logic [dfo_pkg::VERT_W-1:0]  rd_vertex
);

  localparam int IDX_W = $clog2(VERTICES);

  logic [dfo_pkg::VERT_W-1:0] mem [VERTICES];

  // Push write and registered read
  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[req.push_ptr[IDX_W-1:0]] <= req.push_vertex;
    end
    rd_vertex <= mem[req.rd_ptr[IDX_W-1:0]];
  end

endmodule

// ===== sv/graph_depth_first_order_core.sv =====
// ----------------------------------------------------------------------------
// graph_depth_first_order_core
// Edge beats are taken one per cycle. A beat marked last starts a walk and
// holds input off: a first row read, then evaluate and row read per descent,
// evaluate, stack read and row read per backtrack, and evaluate and send the
// flagged final vertex to end. Output back-pressure stretches the walk.
// Reset clears control, the visited marks and the adjacency row valid bits
// directly; no clearing pass.
// ----------------------------------------------------------------------------
module graph_depth_first_order_core #(
  parameter int VERTICES = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  // Input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [dfo_pkg::IN_TDATA_W-1:0]     s_tdata,   // [5:0] vertex_a, [11:6] vertex_b
  input  logic                               s_tuser,   // [0] edge_valid
  input  logic                               s_tlast,   // last_item
  // Output stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [dfo_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [5:0] visited_vertex
  output logic                               m_tlast    // last_visit
);

  localparam int VW      = dfo_pkg::VERT_W;
  localparam int RW      = dfo_pkg::ROW_W;
  localparam int LW      = dfo_pkg::VERT_W + 1;
  localparam int IDX_W   = $clog2(VERTICES);
  localparam int DEPTH_W = $clog2(VERTICES + 1);
  localparam logic [LW-1:0] V_LIM = LW'(VERTICES);

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_EVAL   = 3'd2;
  localparam logic [2:0] S_POP    = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]          state;
  logic [DEPTH_W-1:0]  depth;
  logic [VERTICES-1:0] visited;
  logic [VW-1:0]       top;
  logic [VW-1:0]       pend;

  logic [VW-1:0]       vertex_a;
  logic [VW-1:0]       vertex_b;
  logic                s_accept;
  logic                edge_ok;
  logic                out_free;
  logic [VERTICES-1:0] adj_row;
  logic [VERTICES-1:0] open;
  logic [VW-1:0]       next;
  logic [VERTICES-1:0] next_onehot;
  logic                do_start;
  logic                do_push;
  logic                do_pop;
  logic                do_finish;
  logic [VW-1:0]       stk_vertex;

  dfo_pkg::adj_req_t   adj_req;
  dfo_pkg::stk_req_t   stk_req;

  // Beat decode
  assign vertex_a = s_tdata[VW-1:0];
  assign vertex_b = s_tdata[2*VW-1:VW];
  assign s_tready = (state == S_LOAD);
  assign s_accept = s_tvalid && s_tready;
  assign edge_ok  = s_tuser && ({1'b0, vertex_a} < V_LIM) && ({1'b0, vertex_b} < V_LIM);
  assign out_free = !m_tvalid || m_tready;

  // Next unvisited neighbor of the top vertex
  assign open        = adj_row & ~visited;
  assign next        = dfo_pkg::lowest_set(RW'(open));
  assign next_onehot = {{(VERTICES-1){1'b0}}, 1'b1} << next[IDX_W-1:0];

  // Walk step decisions
  assign do_start  = s_accept && s_tlast;
  assign do_push   = (state == S_EVAL) && (open != '0) && out_free;
  assign do_pop    = (state == S_EVAL) && (open == '0) && (depth != DEPTH_W'(1));
  assign do_finish = (state == S_FINISH) && out_free;

  // Adjacency requests
  always_comb begin
    adj_req.wr_en = s_accept && edge_ok;
    adj_req.wr_a  = vertex_a;
    adj_req.wr_b  = vertex_b;
    adj_req.rd_v  = top;
    adj_req.clear = do_finish;
  end

  // Stack requests: push below the new top, read the entry under the top
  always_comb begin
    stk_req.push        = do_push;
    stk_req.push_ptr    = VW'(depth - DEPTH_W'(1));
    stk_req.push_vertex = top;
    stk_req.rd_ptr      = VW'(depth - DEPTH_W'(2));
  end

  dfo_adj #(
    .VERTICES (VERTICES)
  ) u_adj (
    .clk    (clk),
    .rst    (rst),
    .req    (adj_req),
    .rd_row (adj_row)
  );

  dfo_stack #(
    .VERTICES (VERTICES)
  ) u_stack (
    .clk       (clk),
    .req       (stk_req),
    .rd_vertex (stk_vertex)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      depth    <= '0;
      visited  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // a beat is raised on a push or at the finish, held until taken
      m_tvalid <= do_push || do_finish || (m_tvalid && !m_tready);
      unique case (state)
        S_LOAD: begin
          if (do_start) begin
            visited <= VERTICES'(1);
            depth   <= DEPTH_W'(1);
            state   <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (do_push) begin
            visited  <= visited | next_onehot;
            depth    <= depth + DEPTH_W'(1);
            state    <= S_READ;
          end else if (do_pop) begin
            depth <= depth - DEPTH_W'(1);
            state <= S_POP;
          end else if (open == '0) begin
            state <= S_FINISH;
          end
        end
        S_POP: begin
          state <= S_READ;
        end
        S_FINISH: begin
          if (do_finish) begin
            visited  <= '0;
            depth    <= '0;
            state    <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // Datapath: top vertex, held-back vertex and output beat
  always_ff @(posedge clk) begin
    if (do_start) begin
      top  <= '0;
      pend <= '0;
    end
    if (do_push) begin
      top     <= next;
      pend    <= next;
      m_tdata <= {{(dfo_pkg::OUT_TDATA_W-VW){1'b0}}, pend};
      m_tlast <= 1'b0;
    end
    if (state == S_POP) begin
      top <= stk_vertex;
    end
    if (do_finish) begin
      m_tdata <= {{(dfo_pkg::OUT_TDATA_W-VW){1'b0}}, pend};
      m_tlast <= 1'b1;
    end
  end

endmodule

// ===== verif/dfo_order_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfo_order_checker
// Watches both streams of the depth-first order core. Edge beats are loaded
// into a private adjacency matrix; a beat marked last triggers a software
// depth-first walk from vertex 0, whose preorder is queued and compared
// against the output beats in order.
// ----------------------------------------------------------------------------
module dfo_order_checker #(
  parameter int VERTICES = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  input  logic [dfo_pkg::IN_TDATA_W-1:0]     s_tdata,   // [5:0] vertex_a, [11:6] vertex_b
  input  logic                               s_tuser,   // [0] edge_valid
  input  logic                               s_tlast,   // last_item
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic [dfo_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [5:0] visited_vertex
  input  logic                               m_tlast,   // last_visit
  output int unsigned                        fail_count,
  output int unsigned                        pending
);

  typedef struct packed {
    logic [dfo_pkg::VERT_W-1:0] vertex;
    logic                       is_last;
  } visit_t;

  logic [dfo_pkg::ROW_W-1:0] adj_rows [dfo_pkg::ROW_W];
  visit_t                    visits_due [$];

  function automatic void clear_graph();
    for (int i = 0; i < dfo_pkg::ROW_W; i++) adj_rows[i] = '0;
  endfunction

  // Undirected edge: set both bits, drop ends outside the vertex range
  function automatic void load_edge(input logic [dfo_pkg::VERT_W-1:0] a,
                                    input logic [dfo_pkg::VERT_W-1:0] b);
    if (int'(a) < VERTICES && int'(b) < VERTICES) begin
      adj_rows[a][b] = 1'b1;
      adj_rows[b][a] = 1'b1;
    end
  endfunction

  // Depth-first preorder from vertex 0, lowest open neighbour first
  function automatic void predict_walk();
    logic [dfo_pkg::ROW_W-1:0]  seen;
    logic [dfo_pkg::ROW_W-1:0]  open;
    logic [dfo_pkg::ROW_W-1:0]  live;
    logic [dfo_pkg::VERT_W-1:0] trail [dfo_pkg::ROW_W];
    logic [dfo_pkg::VERT_W-1:0] order_v [$];
    visit_t                     v;
    int                         depth;
    int                         nxt;
    live = '0;
    for (int i = 0; i < VERTICES && i < dfo_pkg::ROW_W; i++) live[i] = 1'b1;
    seen     = {{(dfo_pkg::ROW_W-1){1'b0}}, 1'b1};
    trail[0] = '0;
    depth    = 1;
    order_v.push_back('0);
    while (depth > 0) begin
      open = adj_rows[trail[depth-1]] & ~seen & live;
      if (open == '0) begin
        depth--;
      end else begin
        nxt = 0;
        for (int i = dfo_pkg::ROW_W - 1; i >= 0; i--) if (open[i]) nxt = i;
        seen[nxt] = 1'b1;
        if (depth < dfo_pkg::ROW_W) begin
          trail[depth] = dfo_pkg::VERT_W'(nxt);
          depth++;
        end
        order_v.push_back(dfo_pkg::VERT_W'(nxt));
      end
    end
    for (int i = 0; i < order_v.size(); i++) begin
      v.vertex  = order_v[i];
      v.is_last = (i == order_v.size() - 1);
      visits_due.push_back(v);
    end
    // graph is consumed by the walk
    clear_graph();
  endfunction

  always @(posedge clk) begin : watch
    visit_t want;
    if (rst) begin
      clear_graph();
      visits_due.delete();
      fail_count = 0;
    end else begin
      // input side: edge load first, then the walk on a last beat
      if (s_tvalid === 1'b1 && s_tready === 1'b1) begin
        if (s_tuser) load_edge(s_tdata[dfo_pkg::VERT_W-1:0],
                               s_tdata[2*dfo_pkg::VERT_W-1:dfo_pkg::VERT_W]);
        if (s_tlast) predict_walk();
      end
      // output side: compare against the oldest predicted visit
      if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
        if (visits_due.size() == 0) begin
          $display("%0t: unexpected visit beat: vertex %0d last %0b",
                   $time, m_tdata[dfo_pkg::VERT_W-1:0], m_tlast);
          fail_count++;
        end else begin
          want = visits_due.pop_front();
          if (m_tdata[dfo_pkg::VERT_W-1:0] !== want.vertex || m_tlast !== want.is_last) begin
            $display("%0t: visit mismatch: expected vertex %0d last %0b, got vertex %0d last %0b",
                     $time, want.vertex, want.is_last, m_tdata[dfo_pkg::VERT_W-1:0], m_tlast);
            fail_count++;
          end
        end
      end
    end
    pending = visits_due.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the depth-first order core: a directed set of small graphs
// (edgeless, self loop, duplicates, unreachable parts, edge on the last beat)
// followed by random graphs of varying density and one spanning path that
// visits every vertex. Both stream sides idle at random; the checker module
// predicts and compares the visit order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          VERTICES    = 64;
  localparam int          EDGE_ITEMS  = 210;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [dfo_pkg::IN_TDATA_W-1:0]  s_tdata;
  logic                            s_tuser;
  logic                            s_tlast;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [dfo_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                            m_tlast;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned sink_hold;
  int unsigned cycles;
  int          sent_items;
  bit          src_steady;
  bit          sink_steady;
  bit          path_done;

  graph_depth_first_order_core #(.VERTICES(VERTICES)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  dfo_order_checker #(.VERTICES(VERTICES)) u_order_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("graph_depth_first_order_core verification failed");
    $finish;
  end

  // Output side: after each beat, stall for a random number of cycles
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= !rst && (sink_hold == 0);
    end
  end

  always @(posedge clk) begin
    if (rst)
      sink_hold <= 0;
    else if (m_tvalid === 1'b1 && m_tready)
      sink_hold <= sink_steady ? 0 : $urandom_range(0, 4);
    else if (sink_hold > 0)
      sink_hold <= sink_hold - 1;
  end

  // One input beat; called and returns at a falling edge
  task automatic send_edge(input logic [dfo_pkg::VERT_W-1:0] a,
                           input logic [dfo_pkg::VERT_W-1:0] b,
                           input logic with_edge, input logic ends_graph);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(dfo_pkg::IN_TDATA_W-2*dfo_pkg::VERT_W){1'b0}}, b, a};
    s_tuser  <= with_edge;
    s_tlast  <= ends_graph;
    do @(posedge clk); while (s_tready !== 1'b1);
    @(negedge clk);
    sent_items++;
  endtask

  // Hold the input until every predicted visit has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Random graph with a random vertex span; an occasional edgeless beat
  task automatic send_random_graph();
    int edges;
    int span;
    src_steady  = ($urandom_range(0, 3) == 0);
    sink_steady = ($urandom_range(0, 3) == 0);
    edges = $urandom_range(1, 14);
    case ($urandom_range(0, 3))
      0: span = 7;
      1: span = 15;
      2: span = 31;
      default: span = 63;
    endcase
    for (int i = 0; i < edges; i++) begin
      if ($urandom_range(0, 7) == 0)
        send_edge(dfo_pkg::VERT_W'($urandom), dfo_pkg::VERT_W'($urandom), 1'b0, 1'b0);
      if (i == edges - 1)
        send_edge(dfo_pkg::VERT_W'($urandom_range(0, span)),
                  dfo_pkg::VERT_W'($urandom_range(0, span)),
                  ($urandom_range(0, 3) != 0), 1'b1);
      else
        send_edge(dfo_pkg::VERT_W'($urandom_range(0, span)),
                  dfo_pkg::VERT_W'($urandom_range(0, span)),
                  1'b1, 1'b0);
    end
  endtask

  // Shuffled chain through all vertices: the walk emits every vertex
  task automatic send_full_path();
    logic [dfo_pkg::VERT_W-1:0] order [VERTICES];
    logic [dfo_pkg::VERT_W-1:0] tmp;
    int                         j;
    src_steady  = ($urandom_range(0, 1) == 0);
    sink_steady = 1'b0;
    for (int i = 0; i < VERTICES; i++) order[i] = dfo_pkg::VERT_W'(i);
    for (int i = VERTICES - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < VERTICES - 1; i++)
      send_edge(order[i], order[i+1], 1'b1, (i == VERTICES - 2));
  endtask

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = 1'b0;
    s_tlast     = 1'b0;
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    path_done   = 1'b0;
    sent_items  = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // edgeless graph: vertex 0 alone
    send_edge(6'd0, 6'd0, 1'b0, 1'b1);
    // self loop on vertex 0 only
    send_edge(6'd0, 6'd0, 1'b1, 1'b1);
    // extremes, duplicate, self loop on 63, unreachable pair, ignored fields
    send_edge(6'd0, 6'd63, 1'b1, 1'b0);
    send_edge(6'd63, 6'd63, 1'b1, 1'b0);
    send_edge(6'd0, 6'd63, 1'b1, 1'b0);
    send_edge(6'd1, 6'd63, 1'b1, 1'b0);
    send_edge(6'd5, 6'd0, 1'b1, 1'b0);
    send_edge(6'd20, 6'd21, 1'b1, 1'b0);
    send_edge(6'd42, 6'd42, 1'b0, 1'b0);
    send_edge(6'd42, 6'd17, 1'b0, 1'b1);
    // edge carried on the last beat
    send_edge(6'd7, 6'd0, 1'b1, 1'b1);
    drain();
    // backtracking through a cycle, unreachable edge on the last beat
    src_steady = 1'b1;
    send_edge(6'd0, 6'd3, 1'b1, 1'b0);
    send_edge(6'd3, 6'd2, 1'b1, 1'b0);
    send_edge(6'd2, 6'd4, 1'b1, 1'b0);
    send_edge(6'd0, 6'd1, 1'b1, 1'b0);
    send_edge(6'd1, 6'd4, 1'b1, 1'b0);
    send_edge(6'd62, 6'd61, 1'b1, 1'b1);

    // random graphs, one full spanning path along the way
    sent_items = 0;
    while (sent_items < EDGE_ITEMS) begin
      if (!path_done && sent_items > 60) begin
        send_full_path();
        path_done = 1'b1;
      end else begin
        send_random_graph();
      end
      if ($urandom_range(0, 4) == 0) drain();
    end

    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("graph_depth_first_order_core verification clean");
    else
      $display("graph_depth_first_order_core verification failed");
    $finish;
  end

endmodule
